// File: rtl/sdsb_pkg.sv
// ----------------------------------------------------------------------------
// sdsb_pkg
// Shared constants and types of the stream-bypass DRRIP replacement engine.
// ----------------------------------------------------------------------------
package sdsb_pkg;

    localparam int SETS        = 2048;
    localparam int WAYS        = 16;
    localparam int SIG_BITS    = 6;
    localparam int LEADER_SETS = 64;

    localparam int SET_W       = $clog2(SETS);
    localparam int WAY_W       = 4;
    localparam int SIG_ENTRIES = 1 << SIG_BITS;
    localparam int ADDR_W      = 64;
    localparam int LINE_SHIFT  = 6;
    localparam int PSEL_W      = 10;

    localparam logic [PSEL_W-1:0] PSEL_MID = PSEL_W'(512);
    localparam logic [PSEL_W-1:0] PSEL_MAX = PSEL_W'(1023);

    localparam logic [1:0] RRPV_NEAR = 2'd2;
    localparam logic [1:0] RRPV_FAR  = 2'd3;

    typedef struct packed {
        logic [WAYS-1:0][1:0]          rrpv;
        logic [WAYS-1:0][SIG_BITS-1:0] sig;
        logic [1:0]                    sc;
        logic [ADDR_W-1:0]             paddr;
        logic [ADDR_W-1:0]             pstride;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    localparam row_t RESET_ROW = '{rrpv: '1, sig: '0, sc: '0, paddr: '0, pstride: '0};

    typedef struct packed {
        logic clr;
        logic load;
        logic row_latch;
        logic exec;
        logic ot_upd;
        logic ot_rd;
        logic ot_dep;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic op;
        logic hit;
        logic stream_fill;
        logic out_busy;
    } sts_t;

endpackage

// File: rtl/sdsb_ram.sv
// ----------------------------------------------------------------------------
// sdsb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sdsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/sdsb_ctrl.sv
// ----------------------------------------------------------------------------
// sdsb_ctrl
// Sequencer of the replacement engine: clearing pass, set read, outcome table
// read-modify-write steps and result hand-off.
// ----------------------------------------------------------------------------
module sdsb_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sdsb_pkg::sts_t sts,
    output sdsb_pkg::cmd_t cmd
);
    import sdsb_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_READ   = 8'b0000_0100,
        ST_EXEC   = 8'b0000_1000,
        ST_OT_UPD = 8'b0001_0000,
        ST_OT_RD  = 8'b0010_0000,
        ST_OT_DEP = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_READ;
            end
            ST_READ: state_next = ST_EXEC;
            ST_EXEC: begin
                if (!sts.op || (!sts.hit && sts.stream_fill)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_OT_UPD;
                end
            end
            ST_OT_UPD: begin
                if (sts.hit) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_OT_RD;
                end
            end
            ST_OT_RD:  state_next = ST_OT_DEP;
            ST_OT_DEP: state_next = ST_DONE;
            ST_DONE: begin
                if (!sts.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign cmd.clr       = (state_reg == ST_CLEAR);
    assign cmd.load      = (state_reg == ST_IDLE) && s_valid;
    assign cmd.row_latch = (state_reg == ST_READ);
    assign cmd.exec      = (state_reg == ST_EXEC);
    assign cmd.ot_upd    = (state_reg == ST_OT_UPD);
    assign cmd.ot_rd     = (state_reg == ST_OT_RD);
    assign cmd.ot_dep    = (state_reg == ST_OT_DEP);
    assign cmd.out_load  = (state_reg == ST_DONE) && !sts.out_busy;

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while one is in progress");

    a_clear_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (state_reg == ST_CLEAR) && !sts.clr_last |=> !s_ready)
        else $error("clearing pass cut short");

    a_fill_path: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && cmd.ot_dep |-> $past(cmd.ot_rd) && !sts.hit)
        else $error("depth step without outcome read");

endmodule

// File: rtl/sdsb_dpath.sv
// ----------------------------------------------------------------------------
// sdsb_dpath
// Datapath: per-set state memory, signature outcome table, policy selector,
// victim search, stride detector and insertion depth logic.
// ----------------------------------------------------------------------------
module sdsb_dpath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sdsb_pkg::cmd_t               cmd,
    output sdsb_pkg::sts_t               sts,
    input  logic                         s_op,
    input  logic [sdsb_pkg::SET_W-1:0]   s_set_index,
    input  logic [sdsb_pkg::WAY_W-1:0]   s_way,
    input  logic [sdsb_pkg::ADDR_W-1:0]  s_address,
    input  logic [sdsb_pkg::ADDR_W-1:0]  s_pc,
    input  logic                         s_hit,
    input  logic [4:0]                   s_chance,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sdsb_pkg::WAY_W-1:0]   m_victim_way,
    output logic                         m_streaming
);
    import sdsb_pkg::*;

    logic                op_reg, hit_reg;
    logic [SET_W-1:0]    set_reg;
    logic [WAY_W-1:0]    way_reg;
    logic [ADDR_W-1:0]   addr_reg, pc_reg;
    logic [4:0]          chance_reg;
    logic [SET_W-1:0]    clr_cnt_reg;
    logic [PSEL_W-1:0]   psel_reg, psel_next;
    logic [SIG_BITS-1:0] oldsig_reg, sig_reg;
    logic [WAY_W-1:0]    victim_reg;
    logic                m_valid_reg;
    row_t                row_reg, row_next;

    logic [ROW_W-1:0]    ram_rdata;
    row_t                ram_row;
    logic                row_we;
    logic [1:0]          ot_rdata, ot_wdata;
    logic                ot_we;
    logic [SIG_BITS-1:0] ot_raddr, ot_waddr;

    // Victim search and aging
    logic                has3, has2, has1;
    logic [1:0]          top, add;
    logic [WAY_W-1:0]    pick;
    row_t                aged_row;

    // Stride detector
    logic [ADDR_W-1:0]   stride;
    logic                same_stride;
    logic [1:0]          sc_new;
    row_t                miss_row, hit_row, dep_row;

    logic                srrip_leader, brrip_leader;
    logic [1:0]          depth_base, depth;

    assign ram_row = row_t'(ram_rdata);

    always_comb begin
        has3 = 1'b0;
        has2 = 1'b0;
        has1 = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            has3 = has3 | (row_reg.rrpv[w] == 2'd3);
            has2 = has2 | (row_reg.rrpv[w] == 2'd2);
            has1 = has1 | (row_reg.rrpv[w] == 2'd1);
        end
        top = has3 ? 2'd3 : has2 ? 2'd2 : has1 ? 2'd1 : 2'd0;
        add = 2'd3 - top;
        aged_row = row_reg;
        pick = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            aged_row.rrpv[w] = row_reg.rrpv[w] + add;
            if (row_reg.rrpv[w] == top) pick = WAY_W'(w);
        end
    end

    always_comb begin
        stride = (row_reg.paddr != '0) ? (addr_reg - row_reg.paddr) : '0;
        same_stride = (row_reg.paddr != '0) && (stride != '0) && (stride == row_reg.pstride);
        if (same_stride) begin
            sc_new = (row_reg.sc == 2'd3) ? 2'd3 : row_reg.sc + 2'd1;
        end else begin
            sc_new = (row_reg.sc == 2'd0) ? 2'd0 : row_reg.sc - 2'd1;
        end
        miss_row = row_reg;
        miss_row.sc = sc_new;
        miss_row.paddr = addr_reg;
        miss_row.pstride = stride;
        if (sc_new[1]) begin
            miss_row.rrpv[way_reg] = RRPV_FAR;
            miss_row.sig[way_reg] = '0;
        end
        hit_row = row_reg;
        hit_row.rrpv[way_reg] = 2'd0;
    end

    always_comb begin
        srrip_leader = (set_reg < SET_W'(LEADER_SETS / 2));
        brrip_leader = !srrip_leader && (set_reg < SET_W'(LEADER_SETS));
        if (!srrip_leader && (brrip_leader || (psel_reg >= PSEL_MID))) begin
            depth_base = (chance_reg == 5'd0) ? RRPV_NEAR : RRPV_FAR;
        end else begin
            depth_base = RRPV_NEAR;
        end
        if (ot_rdata >= 2'd2) begin
            depth = RRPV_NEAR;
        end else if (ot_rdata == 2'd0) begin
            depth = RRPV_FAR;
        end else begin
            depth = depth_base;
        end
        dep_row = row_reg;
        dep_row.rrpv[way_reg] = depth;
        dep_row.sig[way_reg] = sig_reg;
        psel_next = psel_reg;
        if (srrip_leader && (psel_reg != PSEL_MAX)) begin
            psel_next = psel_reg + PSEL_W'(1);
        end else if (brrip_leader && (psel_reg != '0)) begin
            psel_next = psel_reg - PSEL_W'(1);
        end
    end

    always_comb begin
        row_next = row_reg;
        row_we = 1'b0;
        if (cmd.row_latch) begin
            row_next = ram_row;
        end else if (cmd.exec) begin
            row_we = !op_reg || hit_reg || sc_new[1];
            if (!op_reg) begin
                row_next = aged_row;
            end else if (hit_reg) begin
                row_next = hit_row;
            end else begin
                row_next = miss_row;
            end
        end else if (cmd.ot_dep) begin
            row_next = dep_row;
            row_we = 1'b1;
        end
    end

    always_comb begin
        ot_raddr = cmd.exec ? row_reg.sig[way_reg] : sig_reg;
        ot_waddr = cmd.clr ? clr_cnt_reg[SIG_BITS-1:0] : oldsig_reg;
        ot_we = 1'b0;
        ot_wdata = 2'd1;
        if (cmd.ot_upd) begin
            if (hit_reg) begin
                ot_we = 1'b1;
                ot_wdata = (ot_rdata == 2'd3) ? 2'd3 : ot_rdata + 2'd1;
            end else begin
                ot_we = (oldsig_reg != '0) && (ot_rdata != 2'd0);
                ot_wdata = ot_rdata - 2'd1;
            end
        end else if (cmd.clr) begin
            ot_we = 1'b1;
        end
    end

    sdsb_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_set_ram (
        .aclk  (aclk),
        .we    (cmd.clr || row_we),
        .waddr (cmd.clr ? clr_cnt_reg : set_reg),
        .wdata (cmd.clr ? ROW_W'(RESET_ROW) : ROW_W'(row_next)),
        .re    (cmd.load),
        .raddr (s_set_index),
        .rdata (ram_rdata)
    );

    sdsb_ram #(.WIDTH(2), .DEPTH(SIG_ENTRIES)) u_outcome_ram (
        .aclk  (aclk),
        .we    (ot_we),
        .waddr (ot_waddr),
        .wdata (ot_wdata),
        .re    (cmd.exec || cmd.ot_rd),
        .raddr (ot_raddr),
        .rdata (ot_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            psel_reg    <= PSEL_MID;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr) clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            if (cmd.ot_dep) psel_reg <= psel_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= s_op;
            set_reg    <= s_set_index;
            way_reg    <= s_way;
            addr_reg   <= s_address;
            pc_reg     <= s_pc;
            hit_reg    <= s_hit;
            chance_reg <= s_chance;
        end
        row_reg <= row_next;
        if (cmd.exec) begin
            oldsig_reg <= row_reg.sig[way_reg];
            sig_reg    <= pc_reg[SIG_BITS-1:0] ^ addr_reg[LINE_SHIFT+SIG_BITS-1:LINE_SHIFT];
            victim_reg <= op_reg ? '0 : pick;
        end
        if (cmd.out_load) begin
            m_victim_way <= victim_reg;
            m_streaming  <= row_reg.sc[1];
        end
    end

    assign m_valid         = m_valid_reg;
    assign sts.clr_last    = (clr_cnt_reg == SET_W'(SETS - 1));
    assign sts.op          = op_reg;
    assign sts.hit         = hit_reg;
    assign sts.stream_fill = sc_new[1];
    assign sts.out_busy    = m_valid_reg && !m_ready;

    a_psel_on_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(psel_reg) |-> $past(cmd.ot_dep))
        else $error("policy selector moved outside a fill");

    a_out_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $fell(m_valid_reg) |-> $past(m_ready))
        else $error("result dropped before it was taken");

    a_victim_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && cmd.exec && op_reg |=> victim_reg == '0)
        else $error("update reported a victim way");

endmodule

// File: rtl/ship_drrip_stream_bypass_replacement.sv
// ----------------------------------------------------------------------------
// ship_drrip_stream_bypass_replacement
// Last-level cache replacement engine: RRIP victim search with aging, DRRIP
// set dueling, signature outcome bias and per-set stream detection.
// ----------------------------------------------------------------------------
// After reset the engine runs a clearing pass over every row of the per-set
// memory and takes no item until it ends. Items are handled one at a time,
// since each one reads, changes and writes back a row of the set memory,
// which has one write and one read port: a victim request or a streaming
// fill passes through the set read, the execute step and the hand-off; a hit
// adds the outcome table update, and any other fill adds the outcome table
// update, the outcome read and the depth step. A finished result waits in an
// output register and holds up only the next item's last step.
module ship_drrip_stream_bypass_replacement (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic [sdsb_pkg::SET_W-1:0]  s_set_index,
    input  logic [sdsb_pkg::WAY_W-1:0]  s_way,
    input  logic [sdsb_pkg::ADDR_W-1:0] s_address,
    input  logic [sdsb_pkg::ADDR_W-1:0] s_pc,
    input  logic                        s_hit,
    input  logic [4:0]                  s_chance,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sdsb_pkg::WAY_W-1:0]  m_victim_way,
    output logic                        m_streaming
);
    import sdsb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sdsb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sdsb_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_op         (s_op),
        .s_set_index  (s_set_index),
        .s_way        (s_way),
        .s_address    (s_address),
        .s_pc         (s_pc),
        .s_hit        (s_hit),
        .s_chance     (s_chance),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_victim_way (m_victim_way),
        .m_streaming  (m_streaming)
    );

endmodule
